// ===== design/signed_int_to_base_digits_top_assert.svh =====
// ----------------------------------------------------------------------------
// signed_int_to_base_digits_top_assert.svh
// Assertion macros for the integer to digit converter. Each macro compiles
// to a concurrent assertion in simulation and to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_BASE_DIGITS_TOP_ASSERT_SVH
`define SIGNED_INT_TO_BASE_DIGITS_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset
`define SIBD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define SIBD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define SIBD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SIBD_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/sibd_pkg.sv =====
// ----------------------------------------------------------------------------
// sibd_pkg
// Shared types, constants and the digit encoding for the converter.
// ----------------------------------------------------------------------------
package sibd_pkg;

    // Input value width
    localparam int VALUE_BITS = 32;
    localparam int CNT_W      = $clog2(VALUE_BITS);

    // Radix register
    localparam int               RADIX_W     = 6;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

    // Character codes
    localparam int        CHAR_W        = 8;
    localparam logic [7:0] CHAR_ZERO     = 8'h30;
    localparam logic [7:0] CHAR_LETTER_A = 8'h61;
    localparam logic [7:0] CHAR_MINUS    = 8'h2D;
    localparam logic [7:0] DECIMAL_TEN   = 8'd10;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_PUSH,
        ST_SIGN
    } t_state;

    // Map a digit value to its ASCII character
    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        begin
            d_ext = {{(CHAR_W-RADIX_W){1'b0}}, d};
            if (d_ext < DECIMAL_TEN) begin
                digit_char = CHAR_ZERO + d_ext;
            end else begin
                digit_char = CHAR_LETTER_A + (d_ext - DECIMAL_TEN);
            end
        end
    endfunction

    // Clamp the radix register into the legal range
    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        begin
            if (r < RADIX_MIN) begin
                clamp_radix = RADIX_MIN;
            end else if (r > RADIX_MAX) begin
                clamp_radix = RADIX_MAX;
            end else begin
                clamp_radix = r;
            end
        end
    endfunction

endpackage

// ===== design/sibd_in_if.sv =====
// ----------------------------------------------------------------------------
// sibd_in_if
// Valid/ready channel that carries one signed value per beat.
// ----------------------------------------------------------------------------
interface sibd_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [sibd_pkg::VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// ===== design/sibd_out_if.sv =====
// ----------------------------------------------------------------------------
// sibd_out_if
// Valid/ready channel that carries one character and its last flag per beat.
// ----------------------------------------------------------------------------
interface sibd_out_if;
    logic                          valid;
    logic                          ready;
    logic [sibd_pkg::CHAR_W-1:0]   character;
    logic                          last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

// ===== design/signed_int_to_base_digits_top.sv =====
// Each digit comes from a full VALUE_BITS-bit restoring divide, then a push into
// the output register; a negative value then gets a '-' push. A new value is
// accepted only when the sequencer is idle, once its final beat has been pushed.
// All digits share one bit-serial divider; an output stall holds the push or sign.
// Reset: synchronous active-low; clears the sequencer, output valid, radix=10.
// ----------------------------------------------------------------------------
// signed_int_to_base_digits_top
// Converts a signed integer to ASCII digits in base 2..36, least significant
// digit first, followed by '-' for negative values; last marks the final beat.
// ----------------------------------------------------------------------------
`include "signed_int_to_base_digits_top_assert.svh"

module signed_int_to_base_digits_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [sibd_pkg::RADIX_W-1:0]  i_cfg_wr_data,
    sibd_in_if.sink                       i_in,
    sibd_out_if.source                    o_out
);

    localparam int VB = sibd_pkg::VALUE_BITS;
    localparam int RW = sibd_pkg::RADIX_W;
    localparam int CW = sibd_pkg::CNT_W;

    sibd_pkg::t_state r_state, n_state;

    logic [RW-1:0]                r_radix;
    logic [RW-1:0]                r_base,   n_base;
    logic [VB-1:0]                r_quo,    n_quo;
    logic [RW-1:0]                r_rem,    n_rem;
    logic [CW-1:0]                r_cnt,    n_cnt;
    logic                         r_neg,    n_neg;
    logic                         r_out_valid, n_out_valid;
    logic [sibd_pkg::CHAR_W-1:0]  r_out_char,  n_out_char;
    logic                         r_out_last,  n_out_last;

    logic          in_beat;
    logic          out_free;
    logic          out_minus;
    logic          div_done;
    logic [VB-1:0] in_bits;
    logic [VB-1:0] in_mag;
    logic [RW:0]   trial;
    logic [RW:0]   trial_sub;
    logic          q_bit;

    // Handshake
    assign i_in.ready  = (r_state == sibd_pkg::ST_IDLE);
    assign in_beat     = i_in.valid && (r_state == sibd_pkg::ST_IDLE);
    assign out_free    = !r_out_valid || o_out.ready;
    assign out_minus   = r_out_valid && (r_out_char == sibd_pkg::CHAR_MINUS);
    assign o_out.valid     = r_out_valid;
    assign o_out.character = r_out_char;
    assign o_out.last      = r_out_last;

    // Take the magnitude; the most negative value maps to 2^(VB-1) exactly
    assign in_bits = i_in.value;
    assign in_mag  = in_bits[VB-1] ? (~in_bits + {{(VB-1){1'b0}}, 1'b1}) : in_bits;

    // Shared restoring divide step: one quotient bit per cycle in the divide state
    assign trial     = {r_rem, r_quo[VB-1]};
    assign q_bit     = (trial >= {1'b0, r_base});
    assign trial_sub = trial - {1'b0, r_base};
    assign div_done  = (r_cnt == CW'(VB-1));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sibd_pkg::ST_IDLE: begin
                if (in_beat) begin
                    n_state = sibd_pkg::ST_DIV;
                end
            end
            sibd_pkg::ST_DIV: begin
                if (div_done) begin
                    n_state = sibd_pkg::ST_PUSH;
                end
            end
            sibd_pkg::ST_PUSH: begin
                if (out_free) begin
                    if (r_quo != '0) begin
                        n_state = sibd_pkg::ST_DIV;
                    end else if (r_neg) begin
                        n_state = sibd_pkg::ST_SIGN;
                    end else begin
                        n_state = sibd_pkg::ST_IDLE;
                    end
                end
            end
            sibd_pkg::ST_SIGN: begin
                if (out_free) begin
                    n_state = sibd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sibd_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and output register updates
    always_comb begin
        n_base      = r_base;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_neg       = r_neg;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        case (r_state)
            sibd_pkg::ST_IDLE: begin
                if (in_beat) begin
                    n_base = sibd_pkg::clamp_radix(r_radix);
                    n_quo  = in_mag;
                    n_rem  = '0;
                    n_cnt  = '0;
                    n_neg  = in_bits[VB-1];
                end
            end
            sibd_pkg::ST_DIV: begin
                // Shift in one dividend bit, subtract the base when it fits
                n_rem = q_bit ? trial_sub[RW-1:0] : trial[RW-1:0];
                n_quo = {r_quo[VB-2:0], q_bit};
                n_cnt = r_cnt + {{(CW-1){1'b0}}, 1'b1};
            end
            sibd_pkg::ST_PUSH: begin
                // Hand the digit to the output register and restart the divider
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = sibd_pkg::digit_char(r_rem);
                    n_out_last  = (r_quo == '0) && !r_neg;
                    n_rem       = '0;
                    n_cnt       = '0;
                end
            end
            sibd_pkg::ST_SIGN: begin
                // Append the minus sign as the final beat
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = sibd_pkg::CHAR_MINUS;
                    n_out_last  = 1'b1;
                end
            end
            default: begin
                n_out_valid = r_out_valid;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sibd_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_radix     <= sibd_pkg::RADIX_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_radix <= i_cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_base     <= n_base;
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_cnt      <= n_cnt;
        r_neg      <= n_neg;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    // Checks
    `SIBD_ASSERT_NXT(a_accept_starts_div, i_clk, i_rst_n, in_beat, r_state == sibd_pkg::ST_DIV)
    `SIBD_ASSERT_IMP(a_rem_below_base, i_clk, i_rst_n, !i_in.ready, r_rem < r_base)
    `SIBD_ASSERT_IMP(a_sign_only_negative, i_clk, i_rst_n, r_state == sibd_pkg::ST_SIGN, r_neg)
    `SIBD_ASSERT_IMP(a_minus_is_last, i_clk, i_rst_n, out_minus, r_out_last)

endmodule
